// ===== hw/rtl/serial_rx_idle_gap_framer_unit_macros.svh =====
// Assertion helpers used by the framer control block.
`ifndef SERIAL_RX_IDLE_GAP_FRAMER_UNIT_MACROS_SVH
`define SERIAL_RX_IDLE_GAP_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRXF_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRXF_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/srxf_pkg.sv =====
package srxf_pkg;

    localparam int FUNC_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 7;
    localparam int LEN_W      = 8;
    localparam int FSIZE_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX_BYTE = 2'd0,
        FUNC_TICK    = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIFO_SIZE  = 2'd1;

    typedef struct packed {
        logic capture;
        logic push;
        logic drain_rd;
        logic drain_wr;
        logic tick_end;
        logic read_issue;
        logic read_take;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic ring_empty;
        logic ring_last;
    } dp_sts_t;

endpackage

// ===== hw/rtl/srxf_datapath.sv =====
module srxf_datapath #(
    parameter int FIFO_DEPTH  = 64,
    parameter int FRAME_DEPTH = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srxf_pkg::dp_cmd_t                   cmd,
    output srxf_pkg::dp_sts_t                   sts,
    input  logic                                cfg_we,
    input  logic [srxf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srxf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [srxf_pkg::BYTE_W-1:0]         rx_byte,
    input  logic [srxf_pkg::INDEX_W-1:0]        read_index,
    output logic                                fifo_overflow,
    output logic                                frame_ready,
    output logic [srxf_pkg::LEN_W-1:0]          frame_length,
    output logic [srxf_pkg::BYTE_W-1:0]         read_data
);

    localparam int RA_W = $clog2(FIFO_DEPTH);
    localparam int RC_W = $clog2(FIFO_DEPTH + 1);
    localparam int LW   = (RC_W > srxf_pkg::FSIZE_W) ? RC_W : srxf_pkg::FSIZE_W;
    localparam int FA_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    logic [srxf_pkg::BYTE_W-1:0]  ring_mem [FIFO_DEPTH];
    logic [srxf_pkg::BYTE_W-1:0]  frame_mem [FRAME_DEPTH];

    logic [7:0]                   idle_ticks_reg;
    logic [srxf_pkg::FSIZE_W-1:0] fifo_size_reg;
    logic [RA_W-1:0]              write_pos_reg;
    logic [RA_W-1:0]              read_pos_reg;
    logic [RC_W-1:0]              ring_count_reg;
    logic [srxf_pkg::LEN_W-1:0]   partial_len_reg;
    logic [7:0]                   idle_left_reg;
    logic [srxf_pkg::LEN_W-1:0]   done_len_reg;

    logic [srxf_pkg::BYTE_W-1:0]  byte_reg;
    logic [srxf_pkg::INDEX_W-1:0] index_reg;
    logic                         res_ovf_reg;
    logic                         res_rdy_reg;
    logic [srxf_pkg::BYTE_W-1:0]  res_data_reg;
    logic [srxf_pkg::BYTE_W-1:0]  ring_q_reg;
    logic [srxf_pkg::BYTE_W-1:0]  frame_q_reg;
    logic                         ovf_out_reg;
    logic                         rdy_out_reg;
    logic [srxf_pkg::LEN_W-1:0]   len_out_reg;
    logic [srxf_pkg::BYTE_W-1:0]  data_out_reg;

    logic [LW-1:0]                size_ext;
    logic [LW-1:0]                lim_wide;
    logic [RC_W-1:0]              ring_lim;
    logic                         ring_full;
    logic [RC_W-1:0]              wp_inc;
    logic [RC_W-1:0]              rp_inc;
    logic [RA_W-1:0]              last_pos;
    logic [RA_W-1:0]              ring_wr_addr;
    logic                         frame_has_room;
    logic [7:0]                   index_ext;
    logic                         index_ok;
    logic [7:0]                   reload;
    logic                         completes;

    // clamp the ring size to 1..FIFO_DEPTH
    always_comb
    begin
        size_ext = LW'(fifo_size_reg);
        if (size_ext == '0)
        begin
            lim_wide = LW'(1);
        end
        else if (size_ext > LW'(FIFO_DEPTH))
        begin
            lim_wide = LW'(FIFO_DEPTH);
        end
        else
        begin
            lim_wide = size_ext;
        end
    end

    assign ring_lim       = RC_W'(lim_wide);
    assign ring_full      = ring_count_reg >= ring_lim;
    assign wp_inc         = RC_W'(write_pos_reg) + RC_W'(1);
    assign rp_inc         = RC_W'(read_pos_reg) + RC_W'(1);
    assign last_pos       = (write_pos_reg == '0) ? RA_W'(ring_lim - RC_W'(1))
                                                  : write_pos_reg - RA_W'(1);
    assign ring_wr_addr   = ring_full ? last_pos : write_pos_reg;
    assign frame_has_room = partial_len_reg < 8'(FRAME_DEPTH);
    assign index_ext      = {1'b0, index_reg};
    assign index_ok       = index_ext < 8'(FRAME_DEPTH);
    assign reload         = (idle_ticks_reg == 8'd0) ? 8'd1 : idle_ticks_reg;
    assign completes      = (partial_len_reg != '0) && (idle_left_reg == 8'd0);

    assign sts.ring_empty = ring_count_reg == '0;
    assign sts.ring_last  = ring_count_reg == RC_W'(1);

    // receive ring: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ring_mem[ring_wr_addr] <= byte_reg;
        end
        if (cmd.drain_rd)
        begin
            ring_q_reg <= ring_mem[read_pos_reg];
        end
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (cmd.drain_wr && frame_has_room)
        begin
            frame_mem[partial_len_reg[FA_W-1:0]] <= ring_q_reg;
        end
        if (cmd.read_issue)
        begin
            frame_q_reg <= frame_mem[index_ext[FA_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg  <= 8'd3;
            fifo_size_reg   <= 7'd64;
            write_pos_reg   <= '0;
            read_pos_reg    <= '0;
            ring_count_reg  <= '0;
            partial_len_reg <= '0;
            idle_left_reg   <= '0;
            done_len_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    srxf_pkg::REG_IDLE_TICKS:
                    begin
                        idle_ticks_reg <= cfg_data;
                    end
                    srxf_pkg::REG_FIFO_SIZE:
                    begin
                        fifo_size_reg  <= cfg_data[srxf_pkg::FSIZE_W-1:0];
                        write_pos_reg  <= '0;
                        read_pos_reg   <= '0;
                        ring_count_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.push && !ring_full)
            begin
                ring_count_reg <= ring_count_reg + RC_W'(1);
                write_pos_reg  <= (wp_inc >= ring_lim) ? '0 : RA_W'(wp_inc);
            end
            if (cmd.drain_wr)
            begin
                ring_count_reg <= ring_count_reg - RC_W'(1);
                read_pos_reg   <= (rp_inc >= ring_lim) ? '0 : RA_W'(rp_inc);
                idle_left_reg  <= reload;
                if (frame_has_room)
                begin
                    partial_len_reg <= partial_len_reg + 8'd1;
                end
            end
            if (cmd.tick_end && (partial_len_reg != '0))
            begin
                if (idle_left_reg == 8'd0)
                begin
                    done_len_reg    <= partial_len_reg;
                    partial_len_reg <= '0;
                end
                else
                begin
                    idle_left_reg <= idle_left_reg - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg     <= rx_byte;
            index_reg    <= read_index;
            res_ovf_reg  <= 1'b0;
            res_rdy_reg  <= 1'b0;
            res_data_reg <= '0;
        end
        if (cmd.push)
        begin
            res_ovf_reg <= ring_full;
        end
        if (cmd.tick_end)
        begin
            res_rdy_reg <= completes;
        end
        if (cmd.read_take)
        begin
            res_data_reg <= index_ok ? frame_q_reg : '0;
        end
        if (cmd.emit)
        begin
            ovf_out_reg  <= res_ovf_reg;
            rdy_out_reg  <= res_rdy_reg;
            len_out_reg  <= done_len_reg;
            data_out_reg <= res_data_reg;
        end
    end

    assign fifo_overflow = ovf_out_reg;
    assign frame_ready   = rdy_out_reg;
    assign frame_length  = len_out_reg;
    assign read_data     = data_out_reg;

endmodule

// ===== hw/rtl/srxf_ctrl.sv =====
`include "serial_rx_idle_gap_framer_unit_macros.svh"

module srxf_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [srxf_pkg::FUNC_W-1:0]   func,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          cfg_ready,
    output srxf_pkg::dp_cmd_t             cmd,
    input  srxf_pkg::dp_sts_t             sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_TICK_CHK,
        ST_DRAIN_RD,
        ST_DRAIN_WR,
        ST_TICK_END,
        ST_READ_ISSUE,
        ST_READ_TAKE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   emit_ok;

    assign emit_ok = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_EMIT) && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (func)
                            srxf_pkg::FUNC_RX_BYTE: state_reg <= ST_PUSH;
                            srxf_pkg::FUNC_TICK:    state_reg <= ST_TICK_CHK;
                            srxf_pkg::FUNC_READ:    state_reg <= ST_READ_ISSUE;
                            default:                state_reg <= ST_EMIT;
                        endcase
                    end
                end
                ST_PUSH:       state_reg <= ST_EMIT;
                ST_TICK_CHK:   state_reg <= sts.ring_empty ? ST_TICK_END : ST_DRAIN_RD;
                ST_DRAIN_RD:   state_reg <= ST_DRAIN_WR;
                ST_DRAIN_WR:   state_reg <= sts.ring_last ? ST_TICK_END : ST_DRAIN_RD;
                ST_TICK_END:   state_reg <= ST_EMIT;
                ST_READ_ISSUE: state_reg <= ST_READ_TAKE;
                ST_READ_TAKE:  state_reg <= ST_EMIT;
                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:       state_reg <= ST_IDLE;
            endcase
        end
    end

    // hold register writes off while an item beat is offered
    assign in_stall  = state_reg != ST_IDLE;
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;
    assign out_valid = out_valid_reg;

    assign cmd.capture    = (state_reg == ST_IDLE) && in_valid;
    assign cmd.push       = state_reg == ST_PUSH;
    assign cmd.drain_rd   = state_reg == ST_DRAIN_RD;
    assign cmd.drain_wr   = state_reg == ST_DRAIN_WR;
    assign cmd.tick_end   = state_reg == ST_TICK_END;
    assign cmd.read_issue = state_reg == ST_READ_ISSUE;
    assign cmd.read_take  = state_reg == ST_READ_TAKE;
    assign cmd.emit       = (state_reg == ST_EMIT) && emit_ok;

    `SRXF_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, cmd.capture, state_reg != ST_IDLE, "accepted beat did not start work")
    `SRXF_ASSERT_IMPLY(a_drain_has_data, clk, rst_n, (state_reg == ST_DRAIN_RD) || (state_reg == ST_DRAIN_WR), !sts.ring_empty, "drain step with empty ring")
    `SRXF_ASSERT_NEXT(a_emit_shows_result, clk, rst_n, cmd.emit, out_valid_reg, "result loaded but not presented")

endmodule

// ===== hw/rtl/serial_rx_idle_gap_framer_unit.sv =====
// Receive framer for one serial channel. Each input beat is one item: a received
// byte (func 0) is queued in a ring FIFO of fifo_size entries, and when the ring is
// full it overwrites the newest entry and flags fifo_overflow; a tick (func 1)
// moves every queued byte into the frame store, each byte reloading the idle
// counter to max(idle_ticks,1), then either completes the partial frame (counter
// at zero: frame_ready, frame_length updated, partial frame cleared) or counts the
// idle counter down; a read (func 2) returns frame store byte read_index, or 0 when
// read_index is at or beyond FRAME_DEPTH. Bytes beyond FRAME_DEPTH in one frame are
// dropped. Every item gives exactly one result beat, and frame_length always shows
// the last completed frame. From acceptance to the result being loaded, a byte
// passes a push step, a read an issue and a take step, and a tick a check step,
// a ring read and a frame store write step per queued byte, and an end step; the
// drain is set by the single ring read port with its registered read data. One item
// is worked at a time; the next item is taken as soon as the result is in the output
// register, even if that result is still stalled. Configuration writes are taken
// only while no item is in work and no item beat is offered.
// Reading a frame store entry that was never written gives an arbitrary byte.
module serial_rx_idle_gap_framer_unit #(
    parameter int FIFO_DEPTH  = 64,
    parameter int FRAME_DEPTH = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [srxf_pkg::FUNC_W-1:0]       func,
    input  logic [srxf_pkg::BYTE_W-1:0]       rx_byte,
    input  logic [srxf_pkg::INDEX_W-1:0]      read_index,
    // result output
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              fifo_overflow,
    output logic                              frame_ready,
    output logic [srxf_pkg::LEN_W-1:0]        frame_length,
    output logic [srxf_pkg::BYTE_W-1:0]       read_data,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srxf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srxf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    srxf_pkg::dp_cmd_t cmd;
    srxf_pkg::dp_sts_t sts;
    logic              cfg_we;

    // a register write lands on the beat where valid meets ready
    assign cfg_we = cfg_valid && cfg_ready;

    // sequencing: accept, step through ring push, ring drain or memory read, load result
    srxf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // ring, frame store, counters, configuration and the output register
    srxf_datapath #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rx_byte       (rx_byte),
        .read_index    (read_index),
        .fifo_overflow (fifo_overflow),
        .frame_ready   (frame_ready),
        .frame_length  (frame_length),
        .read_data     (read_data)
    );

endmodule
